// ===== sv/imuoc_pkg.sv =====
// ----------------------------------------------------------------------------
// imuoc_pkg
// Types, sizes and helpers shared by the IMU offset calibration block.
// ----------------------------------------------------------------------------
package imuoc_pkg;

  localparam int SAMPLE_COUNT_LOG2 = 8;
  localparam int SENSOR_COUNT      = 2;
  localparam int AXES              = 6;
  localparam int VAL_W             = 16;

  localparam int SAMPLE_COUNT = 1 << SAMPLE_COUNT_LOG2;
  // One guard bit above the widest possible sum keeps the sign-extension legal
  // even for a window of one sample.
  localparam int SUM_W  = VAL_W + SAMPLE_COUNT_LOG2 + 1;
  localparam int CNT_W  = (SAMPLE_COUNT_LOG2 > 0) ? SAMPLE_COUNT_LOG2 : 1;
  localparam int BANK_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int OFS_W  = AXES * VAL_W;

  localparam logic ACT_CALIBRATE = 1'b0;
  localparam logic ACT_CORRECT   = 1'b1;
  localparam logic KIND_CORRECTED = 1'b0;
  localparam logic KIND_OFFSETS   = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef val_t [AXES-1:0] axes_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [AXES-1:0] sums_t;

  typedef struct packed {
    logic action;
    logic sensor;
    val_t accel_x;
    val_t accel_y;
    val_t accel_z;
    val_t gyro_x;
    val_t gyro_y;
    val_t gyro_z;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic sensor_out;
    val_t out_accel_x;
    val_t out_accel_y;
    val_t out_accel_z;
    val_t out_gyro_x;
    val_t out_gyro_y;
    val_t out_gyro_z;
  } out_item_t;

  function automatic axes_t item_axes(input in_item_t it);
    axes_t a;
    a[0] = it.accel_x;
    a[1] = it.accel_y;
    a[2] = it.accel_z;
    a[3] = it.gyro_x;
    a[4] = it.gyro_y;
    a[5] = it.gyro_z;
    return a;
  endfunction

  function automatic logic [BANK_W-1:0] bank_of(input logic sensor);
    logic [BANK_W-1:0] b;
    b = (SENSOR_COUNT > 1) ? BANK_W'(sensor) : '0;
    return b;
  endfunction

endpackage

// ===== sv/imuoc_ram.sv =====
// ----------------------------------------------------------------------------
// imuoc_ram
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module imuoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/imu_offset_calibrate_correct.sv =====
// ----------------------------------------------------------------------------
// imu_offset_calibrate_correct
// IMU bias averaging and offset removal for six-axis samples.
// ----------------------------------------------------------------------------
// Input items carry an action, a sensor index and six signed 16-bit readings.
// A calibration item adds its readings to six running sums; the item that
// completes a window of 2^SAMPLE_COUNT_LOG2 samples produces one result with
// kind set, holding the averages (truncated toward zero), which also become
// that sensor's stored offsets. Other calibration items produce no result.
// A correction item produces one result: its readings minus the sensor's
// offsets, wrapping at 16 bits.
//
// Offsets live in a small RAM, one 96-bit row per sensor. An item reads its
// row when accepted and its result is formed in the next cycle, then held in
// the output register. One item is accepted per cycle while the output is
// drained. An offset update followed directly by a correction of the same
// sensor is forwarded around the RAM's registered read.
//
// When out_stall is held, one result waits in the output register and one
// more in the compute stage; in_stall then rises. Reset clears the sums, the
// count and the per-row valid bits, so all offsets read as zero; no clearing
// pass is needed and items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module imu_offset_calibrate_correct
  import imuoc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Accept side
  logic              in_acc;
  logic              in_done_win;
  logic              in_enter;
  logic [BANK_W-1:0] in_bank;
  axes_t             in_vals;
  sums_t             sum_add;

  // Calibration state
  sums_t             sums_r, sums_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SENSOR_COUNT-1:0] ofs_vld_r, ofs_vld_nxt;

  // Compute stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_kind_r;
  logic              s1_sensor_r;
  logic [BANK_W-1:0] s1_bank_r;
  axes_t             s1_vals_r;
  sums_t             s1_sums_r;
  logic              s1_ovld_r;
  logic              fwd_hit_r;
  axes_t             fwd_data_r;
  logic              s1_adv;
  axes_t             avg;
  axes_t             ofs;
  axes_t             res;
  logic [OFS_W-1:0]  ram_rdata;
  axes_t             ram_axes;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign in_bank     = bank_of(in_data.sensor);
  assign in_vals     = item_axes(in_data);
  assign in_done_win = (cnt_r == CNT_W'(SAMPLE_COUNT - 1));
  assign in_enter    = (in_data.action == ACT_CORRECT) || in_done_win;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sum_add[i] = sums_r[i] + {{(SUM_W-VAL_W){in_vals[i][VAL_W-1]}}, in_vals[i]};
    end
  end

  always_comb begin
    sums_nxt = sums_r;
    cnt_nxt  = cnt_r;
    if (in_acc && in_data.action == ACT_CALIBRATE) begin
      if (in_done_win) begin
        sums_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        sums_nxt = sum_add;
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc && in_enter) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Averages: bias negative sums so the arithmetic shift truncates toward zero.
  always_comb begin
    sum_t adj;
    for (int i = 0; i < AXES; i++) begin
      adj    = s1_sums_r[i] + (s1_sums_r[i][SUM_W-1] ? SUM_W'(SAMPLE_COUNT - 1) : '0);
      avg[i] = VAL_W'(adj >>> SAMPLE_COUNT_LOG2);
    end
  end

  assign ram_axes = axes_t'(ram_rdata);

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (fwd_hit_r) begin
        ofs[i] = fwd_data_r[i];
      end else if (s1_ovld_r) begin
        ofs[i] = ram_axes[i];
      end else begin
        ofs[i] = '0;
      end
      res[i] = (s1_kind_r == KIND_OFFSETS) ? avg[i] : val_t'(s1_vals_r[i] - ofs[i]);
    end
  end

  always_comb begin
    ofs_vld_nxt = ofs_vld_r;
    if (s1_adv && s1_kind_r == KIND_OFFSETS) begin
      ofs_vld_nxt[s1_bank_r] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  imuoc_ram #(
    .WIDTH (OFS_W),
    .DEPTH (SENSOR_COUNT)
  ) u_ofs_ram (
    .clk   (clk),
    .we    (s1_adv && s1_kind_r == KIND_OFFSETS),
    .waddr (s1_bank_r),
    .wdata (OFS_W'(avg)),
    .re    (in_acc),
    .raddr (in_bank),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r      <= '0;
      cnt_r       <= '0;
      ofs_vld_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sums_r      <= sums_nxt;
      cnt_r       <= cnt_nxt;
      ofs_vld_r   <= ofs_vld_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_enter) begin
      s1_kind_r   <= (in_data.action == ACT_CORRECT) ? KIND_CORRECTED : KIND_OFFSETS;
      s1_sensor_r <= in_data.sensor;
      s1_bank_r   <= in_bank;
      s1_vals_r   <= in_vals;
      s1_sums_r   <= sum_add;
      // A row being written this very cycle is not seen by the RAM read.
      s1_ovld_r   <= ofs_vld_r[in_bank];
      fwd_hit_r   <= s1_adv && (s1_kind_r == KIND_OFFSETS) && (s1_bank_r == in_bank);
      fwd_data_r  <= avg;
    end
    if (s1_adv) begin
      out_data_r <= '{kind:        s1_kind_r,
                      sensor_out:  s1_sensor_r,
                      out_accel_x: res[0],
                      out_accel_y: res[1],
                      out_accel_z: res[2],
                      out_gyro_x:  res[3],
                      out_gyro_y:  res[4],
                      out_gyro_z:  res[5]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input only stalls behind a result held in the compute stage.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with an empty compute stage");

  // The item that closes a window always restarts the count.
  a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_CALIBRATE && in_done_win) |=> (cnt_r == '0))
    else $error("sample count not cleared after a full window");

  // A stored offset row is marked valid from the next cycle on.
  a_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_kind_r == KIND_OFFSETS) |=> ofs_vld_r[$past(s1_bank_r)])
    else $error("offset row not marked valid after its write");

  // Forwarded offsets always come from a write that has marked its row valid.
  a_fwd_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && fwd_hit_r) |-> ofs_vld_r[s1_bank_r])
    else $error("offsets forwarded for a row that was never written");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule
